// ----- hw/rtl/flr_pkg.sv -----
// Shared types and constants for the fixed-point line rasterizer.
// No dependencies; imported by every module of the block.
package flr_pkg;

  localparam int COORD_IN_W = 13;  // signed endpoint fields
  localparam int MAG_W      = 13;  // span magnitudes
  localparam int COLOR_W    = 32;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] CANVAS_RESET     = 13'd4096;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_REJECT,
    CMD_STEP
  } flr_kind_e;

  typedef enum logic {
    ST_READY,
    ST_DIVIDE
  } flr_state_e;

  // Classified request as it travels from front to back.
  typedef struct packed {
    flr_kind_e              kind;
    logic                   y_major;
    logic                   down;
    logic                   neg;
    logic [COORD_IN_W-1:0]  major0;
    logic [COORD_IN_W-1:0]  major_end;
    logic [COORD_IN_W-1:0]  minor0;
    logic [MAG_W-1:0]       minor_mag;
    logic [MAG_W-1:0]       major_mag;
    logic [COLOR_W-1:0]     color;
  } flr_cmd_t;

endpackage

// ----- hw/rtl/flr_front.sv -----
// Front end: canvas registers, bound check and axis selection.
// Depends on flr_pkg.
module flr_front import flr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         command_i,
  input  logic signed [COORD_IN_W-1:0] start_x_i,
  input  logic signed [COORD_IN_W-1:0] start_y_i,
  input  logic signed [COORD_IN_W-1:0] end_x_i,
  input  logic signed [COORD_IN_W-1:0] end_y_i,
  input  logic [COLOR_W-1:0]           line_color_i,
  output flr_cmd_t                     cmd_o
);

  localparam int LimW = 17;
  localparam logic [LimW-1:0] Cap = LimW'(1) << COORD_BITS;

  logic [CFG_DATA_W-1:0] canvas_w_q, canvas_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= CANVAS_RESET;
      canvas_h_q <= CANVAS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CANVAS_WIDTH:  canvas_w_q <= cfg_data_i;
        REG_CANVAS_HEIGHT: canvas_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic on_axis(logic [COORD_IN_W-1:0] c, logic [CFG_DATA_W-1:0] limit);
    logic [LimW-1:0] lim;
    lim = ({4'b0, limit} > Cap) ? Cap : {4'b0, limit};
    return !c[COORD_IN_W-1] && ({4'b0, c} < lim);
  endfunction

  logic [COORD_IN_W:0] dx, dy, adx, ady, maj_len, min_len;
  logic                valid, y_major;

  always_comb begin
    valid = on_axis(start_x_i, canvas_w_q) && on_axis(end_x_i, canvas_w_q) &&
            on_axis(start_y_i, canvas_h_q) && on_axis(end_y_i, canvas_h_q);
    dx  = {end_x_i[COORD_IN_W-1], end_x_i} - {start_x_i[COORD_IN_W-1], start_x_i};
    dy  = {end_y_i[COORD_IN_W-1], end_y_i} - {start_y_i[COORD_IN_W-1], start_y_i};
    adx = dx[COORD_IN_W] ? -dx : dx;
    ady = dy[COORD_IN_W] ? -dy : dy;
    y_major = ady > adx;  // ties stay on x
    maj_len = y_major ? dy : dx;
    min_len = y_major ? dx : dy;

    if (command_i)   cmd_o.kind = CMD_STEP;
    else if (valid)  cmd_o.kind = CMD_START;
    else             cmd_o.kind = CMD_REJECT;
    cmd_o.y_major   = y_major;
    cmd_o.down      = maj_len[COORD_IN_W] || (maj_len == '0);
    cmd_o.neg       = maj_len[COORD_IN_W] ^ min_len[COORD_IN_W];
    cmd_o.major0    = y_major ? start_y_i : start_x_i;
    cmd_o.major_end = y_major ? end_y_i : end_x_i;
    cmd_o.minor0    = y_major ? start_x_i : start_y_i;
    cmd_o.major_mag = y_major ? ady[MAG_W-1:0] : adx[MAG_W-1:0];
    cmd_o.minor_mag = y_major ? adx[MAG_W-1:0] : ady[MAG_W-1:0];
    cmd_o.color     = line_color_i;
  end

endmodule

// ----- hw/rtl/flr_queue.sv -----
// Short request queue between front and back ends.
// Depends on flr_pkg.
module flr_queue import flr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  flr_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output flr_cmd_t data_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  flr_cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      count_q <= count_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> full_o) else $error("queue lost full state");
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !do_push) |=> empty_o) else $error("queue invented entry");
`endif

endmodule

// ----- hw/rtl/flr_divider.sv -----
// Radix-2 restoring divider for the 16.16 slope, one quotient bit per cycle.
// Depends on flr_pkg. Requires numerator <= denominator, denominator nonzero.
module flr_divider import flr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [MAG_W-1:0]     num_i,
  input  logic [MAG_W-1:0]     den_i,
  output logic                 done_o,
  output logic [FRAC_BITS:0]   quot_o
);

  localparam int CntW = $clog2(FRAC_BITS + 1);

  logic               busy_q, done_q;
  logic [CntW-1:0]    cnt_q;
  logic [MAG_W-1:0]   rem_q, den_q;
  logic [FRAC_BITS:0] quot_q;
  logic [MAG_W:0]     trial;
  logic               qbit;

  // First pass yields the integer bit, the rest shift in zeros.
  always_comb begin
    trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    qbit  = trial >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q  <= qbit ? MAG_W'(trial - {1'b0, den_q}) : trial[MAG_W-1:0];
      quot_q <= {quot_q[FRAC_BITS-1:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(FRAC_BITS));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(FRAC_BITS)) busy_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/flr_back.sv -----
// Back end: line setup, DDA stepping and the result register.
// Depends on flr_pkg and flr_divider.
module flr_back import flr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  flr_cmd_t              cmd_i,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic [COLOR_W-1:0]    pixel_color_o,
  output logic                  last_pixel_o,
  output logic                  line_rejected_o
);

  flr_state_e             state_q, state_d;
  logic                   active_q, active_d;
  logic [ACC_W-1:0]       acc_q, acc_d, slope_q, slope_d;
  logic [COORD_IN_W-1:0]  pos_q, pos_d, end_q, end_d;
  logic                   ymaj_q, ymaj_d, down_q, down_d, neg_q, neg_d;
  logic [COLOR_W-1:0]     color_q, color_d;

  logic                   out_valid_q, out_valid_d, out_load;
  logic [COORD_BITS-1:0]  out_x_q, out_x_d, out_y_q, out_y_d;
  logic [COLOR_W-1:0]     out_color_q, out_color_d;
  logic                   out_last_q, out_last_d, out_rej_q, out_rej_d;

  logic                   div_start, div_done;
  logic [FRAC_BITS:0]     quot;
  logic                   slot_free, last;
  logic [COORD_BITS-1:0]  minor_pix, major_pix;
  logic [15:0]            pos_ext;
  logic [ACC_W-1:0]       quot_ext;

  flr_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (cmd_i.minor_mag),
    .den_i   (cmd_i.major_mag),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign slot_free = !out_valid_q || pop_i;
  assign last      = (pos_q == end_q);
  assign minor_pix = acc_q[FRAC_BITS +: COORD_BITS];
  assign pos_ext   = {{(16 - COORD_IN_W){1'b0}}, pos_q};
  assign major_pix = pos_ext[COORD_BITS-1:0];
  assign quot_ext  = ACC_W'(quot);

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    acc_d       = acc_q;
    slope_d     = slope_q;
    pos_d       = pos_q;
    end_d       = end_q;
    ymaj_d      = ymaj_q;
    down_d      = down_q;
    neg_d       = neg_q;
    color_d     = color_q;
    out_load    = 1'b0;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    out_rej_d   = out_rej_q;
    q_pop_o     = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      ST_READY: begin
        if (!q_empty_i) begin
          case (cmd_i.kind)
            CMD_START: begin
              q_pop_o  = 1'b1;
              ymaj_d   = cmd_i.y_major;
              down_d   = cmd_i.down;
              neg_d    = cmd_i.neg;
              pos_d    = cmd_i.major0;
              end_d    = cmd_i.major_end;
              color_d  = cmd_i.color;
              acc_d    = (ACC_W'(cmd_i.minor0) << FRAC_BITS) +
                         (ACC_W'(1) << (FRAC_BITS - 1));
              if (cmd_i.major_mag == '0) begin
                slope_d  = '0;
                active_d = 1'b1;
              end else begin
                div_start = 1'b1;
                active_d  = 1'b0;
                state_d   = ST_DIVIDE;
              end
            end
            CMD_REJECT: begin
              if (slot_free) begin
                q_pop_o     = 1'b1;
                active_d    = 1'b0;
                out_load    = 1'b1;
                out_x_d     = '0;
                out_y_d     = '0;
                out_color_d = '0;
                out_last_d  = 1'b0;
                out_rej_d   = 1'b1;
              end
            end
            CMD_STEP: begin
              if (!active_q) begin
                q_pop_o = 1'b1;  // idle step: dropped silently
              end else if (slot_free) begin
                q_pop_o     = 1'b1;
                out_load    = 1'b1;
                out_x_d     = ymaj_q ? minor_pix : major_pix;
                out_y_d     = ymaj_q ? major_pix : minor_pix;
                out_color_d = color_q;
                out_last_d  = last;
                out_rej_d   = 1'b0;
                if (last) begin
                  active_d = 1'b0;
                end else if (down_q) begin
                  pos_d = pos_q - COORD_IN_W'(1);
                  acc_d = acc_q - slope_q;
                end else begin
                  pos_d = pos_q + COORD_IN_W'(1);
                  acc_d = acc_q + slope_q;
                end
              end
            end
            default: q_pop_o = 1'b1;
          endcase
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          slope_d  = neg_q ? -quot_ext : quot_ext;
          active_d = 1'b1;
          state_d  = ST_READY;
        end
      end
      default: state_d = ST_READY;
    endcase

    if (out_load)              out_valid_d = 1'b1;
    else if (pop_i)            out_valid_d = 1'b0;
    else                       out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READY;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    slope_q     <= slope_d;
    pos_q       <= pos_d;
    end_q       <= end_d;
    ymaj_q      <= ymaj_d;
    down_q      <= down_d;
    neg_q       <= neg_d;
    color_q     <= color_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
    out_rej_q   <= out_rej_d;
  end

  assign empty_o         = !out_valid_q;
  assign pixel_x_o       = out_x_q;
  assign pixel_y_o       = out_y_q;
  assign pixel_color_o   = out_color_q;
  assign last_pixel_o    = out_last_q;
  assign line_rejected_o = out_rej_q;

`ifndef SYNTHESIS
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVIDE)) else $error("slope done outside setup");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || pop_i)) else $error("result overwritten");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i) else $error("pop from empty queue");
  a_idle_in_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> !active_q) else $error("stepping during setup");
`endif

endmodule

// ----- hw/rtl/fixed_point_line_rasterizer.sv -----
// Fixed-point DDA line rasterizer top level: front end, request queue, back end.
// Depends on flr_pkg, flr_front, flr_queue, flr_back (which holds flr_divider).
// Step requests: pixels go through the queue and the result register, one per cycle while
// no setup runs and the result register is free. Start requests: popped once the back end
// is ready; the serial slope divider then holds it in setup (none for a zero span).
// Reset is asynchronous, active low: canvas 4096 x 4096, no line, queues empty.
module fixed_point_line_rasterizer import flr_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: register index 0 is canvas width, 1 is canvas height
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  // request side
  input  logic                         push,
  output logic                         full,
  input  logic                         command_i,
  input  logic signed [COORD_IN_W-1:0] start_x_i,
  input  logic signed [COORD_IN_W-1:0] start_y_i,
  input  logic signed [COORD_IN_W-1:0] end_x_i,
  input  logic signed [COORD_IN_W-1:0] end_y_i,
  input  logic [COLOR_W-1:0]           line_color_i,
  // result side
  output logic                         empty,
  input  logic                         pop,
  output logic [COORD_BITS-1:0]        pixel_x_o,
  output logic [COORD_BITS-1:0]        pixel_y_o,
  output logic [COLOR_W-1:0]           pixel_color_o,
  output logic                         last_pixel_o,
  output logic                         line_rejected_o
);

  // Classified request from the front end, straight into the queue.
  flr_cmd_t front_cmd, queue_cmd;
  logic     queue_empty, queue_pop;

  // Front end: holds the canvas registers, rejects off-canvas lines,
  // picks the major axis and the span magnitudes for the divider.
  flr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (command_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .line_color_i (line_color_i),
    .cmd_o        (front_cmd)
  );

  // Two-entry queue lets requests keep arriving while the back end
  // sits in slope setup or waits on a stalled result.
  flr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (queue_pop),
    .empty_o (queue_empty),
    .data_o  (queue_cmd)
  );

  // Back end: runs setup and the DDA walk; its result register decouples
  // the pixel stream from the consumer's pop.
  flr_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (queue_cmd),
    .q_empty_i       (queue_empty),
    .q_pop_o         (queue_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_color_o   (pixel_color_o),
    .last_pixel_o    (last_pixel_o),
    .line_rejected_o (line_rejected_o)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fixed_point_line_rasterizer: queued line and step
// requests, an in-bench DDA predictor and a result monitor. Needs flr_pkg and the RTL.
module tb;
  import flr_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  // request codes on command_i
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;
  // indexes past the last register: writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic                         cmd;
    logic signed [COORD_IN_W-1:0] sx, sy, ex, ey;
    logic [COLOR_W-1:0]           color;
    bit                           hold;  // wait for all pixels before sending
  } line_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  last_pixel;
    logic                  line_rejected;
  } pixel_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i = '0;
  logic                         push = 1'b0;
  logic                         full;
  logic                         command_i = OP_STEP;
  logic signed [COORD_IN_W-1:0] start_x_i = '0;
  logic signed [COORD_IN_W-1:0] start_y_i = '0;
  logic signed [COORD_IN_W-1:0] end_x_i = '0;
  logic signed [COORD_IN_W-1:0] end_y_i = '0;
  logic [COLOR_W-1:0]           line_color_i = '0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [COORD_BITS-1:0]        pixel_x_o;
  logic [COORD_BITS-1:0]        pixel_y_o;
  logic [COLOR_W-1:0]           pixel_color_o;
  logic                         last_pixel_o;
  logic                         line_rejected_o;

  fixed_point_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .line_color_i   (line_color_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .pixel_color_o  (pixel_color_o),
    .last_pixel_o   (last_pixel_o),
    .line_rejected_o(line_rejected_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: canvas registers plus the DDA walker, updated per request.
  // ---------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] canvas_w = CANVAS_RESET;
  logic [CFG_DATA_W-1:0] canvas_h = CANVAS_RESET;
  bit                    line_live;
  logic [ACC_W-1:0]      minor_acc;
  logic [ACC_W-1:0]      slope_q;
  logic [COORD_IN_W-1:0] major_pos;
  logic [COORD_IN_W-1:0] major_stop;
  bit                    y_major;
  bit                    walk_down;
  logic [COLOR_W-1:0]    line_rgb;

  line_req_t request_q[$];       // requests waiting for the driver
  pixel_t    expected_pixels[$]; // predicted results, oldest first
  int        queued_cnt;
  int        accepted_cnt;
  int        n_fail;

  // Coordinate must be >= 0 and below both the register and 2^COORD_BITS.
  function automatic bit on_canvas(logic signed [COORD_IN_W-1:0] c,
                                   logic [CFG_DATA_W-1:0] lim);
    int cap;
    cap = (lim > (1 << COORD_BITS)) ? (1 << COORD_BITS) : int'(lim);
    return (c >= 0) && (int'(c) < cap);
  endfunction

  function automatic void rasterize_request(line_req_t r);
    int     x0, y0, x1, y1;
    int     minor_len, major_len, major0, minor0, t;
    longint q;
    pixel_t px;
    logic [COORD_BITS-1:0] minor_c, major_c;
    bit     at_end;
    px = '0;
    if (r.cmd == OP_START) begin
      x0 = r.sx; y0 = r.sy; x1 = r.ex; y1 = r.ey;
      if (!on_canvas(r.sx, canvas_w) || !on_canvas(r.ex, canvas_w) ||
          !on_canvas(r.sy, canvas_h) || !on_canvas(r.ey, canvas_h)) begin
        // off canvas: zeroed pixel with the reject flag, walker stops
        line_live = 1'b0;
        px.line_rejected = 1'b1;
        expected_pixels.push_back(px);
        return;
      end
      line_rgb  = r.color;
      minor_len = y1 - y0;
      major_len = x1 - x0;
      major0    = x0;
      minor0    = y0;
      y_major   = 1'b0;
      // ties stay on x
      if ((minor_len < 0 ? -minor_len : minor_len) >
          (major_len < 0 ? -major_len : major_len)) begin
        t         = minor_len;
        minor_len = major_len;
        major_len = t;
        major0    = y0;
        minor0    = x0;
        y_major   = 1'b1;
      end
      q = 0;
      if (major_len != 0)
        q = (longint'(minor_len) * (longint'(1) << FRAC_BITS)) / longint'(major_len);
      slope_q    = q[ACC_W-1:0];
      walk_down  = !(major_len > 0);
      major_pos  = 13'(major0);
      major_stop = 13'(major0 + major_len);
      minor_acc  = (32'(minor0) << FRAC_BITS) + (32'd1 << (FRAC_BITS - 1));
      line_live  = 1'b1;
      return;
    end
    if (!line_live) return;  // step while idle: ignored
    minor_c = minor_acc[FRAC_BITS +: COORD_BITS];
    major_c = major_pos[COORD_BITS-1:0];
    at_end  = (major_pos == major_stop);
    px.pixel_x     = y_major ? minor_c : major_c;
    px.pixel_y     = y_major ? major_c : minor_c;
    px.pixel_color = line_rgb;
    px.last_pixel  = at_end;
    expected_pixels.push_back(px);
    if (at_end) begin
      line_live = 1'b0;
    end else if (walk_down) begin
      major_pos = major_pos - 1'b1;
      minor_acc = minor_acc - slope_q;
    end else begin
      major_pos = major_pos + 1'b1;
      minor_acc = minor_acc + slope_q;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops request_q, leaving a random gap before each request, with
  // gap-free bursts. A request marked hold waits until no pixel is pending.
  // ---------------------------------------------------------------------------
  line_req_t cur_req;
  int        gap_left;
  bit        send_burst;

  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    bit fire;
    if (!rst_ni) begin
      push     <= 1'b0;
      gap_left = 0;
    end else begin
      fire = push;
      if (push && !full) begin
        rasterize_request(cur_req);
        accepted_cnt++;
        fire = 1'b0;
        if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
        gap_left = send_burst ? 0 : $urandom_range(0, 8);
      end
      if (!fire) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() != 0 &&
                     !(request_q[0].hold && expected_pixels.size() != 0)) begin
          cur_req      = request_q.pop_front();
          fire         = 1'b1;
          command_i    <= cur_req.cmd;
          start_x_i    <= cur_req.sx;
          start_y_i    <= cur_req.sy;
          end_x_i      <= cur_req.ex;
          end_y_i      <= cur_req.ey;
          line_color_i <= cur_req.color;
        end
      end
      push <= fire;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pops results with a random stall per result, checks each field
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  bit recv_burst;

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    pixel_t want_px;
    bit     take;
    int     stall_left;
    if (!rst_ni) begin
      pop        <= 1'b0;
      stall_left = 0;
    end else begin
      take = pop;
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: x=%0d y=%0d rejected=%0b",
                 pixel_x_o, pixel_y_o, line_rejected_o);
          n_fail++;
        end else begin
          want_px = expected_pixels.pop_front();
          check_field("pixel_x", want_px.pixel_x, pixel_x_o);
          check_field("pixel_y", want_px.pixel_y, pixel_y_o);
          check_field("pixel_color", want_px.pixel_color, pixel_color_o);
          check_field("last_pixel", want_px.last_pixel, last_pixel_o);
          check_field("line_rejected", want_px.line_rejected, line_rejected_o);
        end
        take = 1'b0;
        if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
        stall_left = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (!take) begin
        if (stall_left > 0) stall_left--;
        else take = 1'b1;
      end
      pop <= take;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_item(logic cmd, int sx, int sy, int ex, int ey,
                                     logic [COLOR_W-1:0] color, bit hold = 1'b0);
    line_req_t r;
    r.cmd   = cmd;
    r.sx    = 13'(sx);
    r.sy    = 13'(sy);
    r.ex    = 13'(ex);
    r.ey    = 13'(ey);
    r.color = color;
    r.hold  = hold;
    request_q.push_back(r);
    queued_cnt++;
  endfunction

  // Step fields are don't-care; keep them random.
  function automatic void queue_step();
    queue_item(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  function automatic int pick_coord(int lim);
    return $urandom_range(0, lim - 1);
  endfunction

  // Boundary values just off the canvas (-1, the limit), 4095, on-canvas values or anything.
  function automatic int noisy_coord(int lim);
    case ($urandom_range(0, 4))
      0:       return $urandom;
      1:       return -1;
      2:       return lim;
      3:       return 4095;
      default: return pick_coord(lim);
    endcase
  endfunction

  // Well-formed line: start then a walk of steps. Usually the full walk,
  // sometimes cut short (abandoned by the next start) or overrun (idle steps).
  // Returns the number of requests that do real work.
  function automatic int queue_line(int lw, int lh, bit hold);
    int span, x0, y0, x1, y1, n, pixels, sel;
    sel  = $urandom_range(0, 99);
    span = (sel < 70) ? 8 : (sel < 95) ? 64 : 4095;
    x0 = pick_coord(lw);
    y0 = pick_coord(lh);
    x1 = x0 + $urandom_range(0, 2 * span) - span;
    y1 = y0 + $urandom_range(0, 2 * span) - span;
    if (x1 < 0) x1 = 0;
    if (x1 > lw - 1) x1 = lw - 1;
    if (y1 < 0) y1 = 0;
    if (y1 > lh - 1) y1 = lh - 1;
    pixels = ((x1 > x0) ? x1 - x0 : x0 - x1);
    if (((y1 > y0) ? y1 - y0 : y0 - y1) > pixels) pixels = (y1 > y0) ? y1 - y0 : y0 - y1;
    pixels++;
    n = pixels;
    sel = $urandom_range(0, 9);
    if (sel == 0) n = $urandom_range(0, pixels - 1);
    else if (sel == 1) n = pixels + $urandom_range(1, 3);
    if (n > 80) n = 80;  // long lines get abandoned part way
    queue_item(OP_START, x0, y0, x1, y1, $urandom, hold);
    for (int i = 0; i < n; i++) queue_step();
    return 1 + ((n < pixels) ? n : pixels);
  endfunction

  // Block idle: all requests accepted, all pixels popped, and every queued
  // slope setup (up to three starts in line) run to completion.
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || expected_pixels.size() != 0) @(negedge clk_i);
    repeat (3 * (FRAC_BITS + 2) + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_CANVAS_WIDTH) canvas_w = data;
    else if (idx == REG_CANVAS_HEIGHT) canvas_h = data;
  endtask

  // One canvas setting and a random mix of lines, holds and noise.
  task automatic run_phase(int w, int h, int budget);
    int done, lw, lh, sel;
    wait_idle();
    write_reg(REG_CANVAS_WIDTH, 13'(w));
    write_reg(REG_CANVAS_HEIGHT, 13'(h));
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 13'($urandom));
    lw = (canvas_w > 4096) ? 4096 : canvas_w;
    lh = (canvas_h > 4096) ? 4096 : canvas_h;
    done = 0;
    while (done < budget) begin
      sel = $urandom_range(0, 99);
      if (lw == 0 || lh == 0) begin
        // nothing fits: every start is rejected
        queue_item(OP_START, $urandom, $urandom, $urandom, $urandom, $urandom);
        done++;
      end else if (sel < 85) begin
        done += queue_line(lw, lh, $urandom_range(0, 49) == 0);
      end else if (sel < 95) begin
        queue_item(OP_START, noisy_coord(lw), noisy_coord(lh),
                   noisy_coord(lw), noisy_coord(lh), $urandom);
        done++;
      end else begin
        queue_step();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset canvas 4096 x 4096
    queue_item(OP_START, 0, 0, 0, 0, 32'h0000_0000);  // degenerate at origin
    queue_step();                                     // its only pixel, last
    queue_step();                                     // idle step, no result
    queue_item(OP_START, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF);
    queue_step();
    queue_item(OP_START, 0, 0, 4095, 4095, 32'hA5A5_A5A5);  // tie goes to x
    repeat (3) queue_step();
    // steep line walking down in y, abandons the diagonal
    queue_item(OP_START, 3, 20, 10, 2, 32'h1234_5678);
    repeat (4) queue_step();
    // shallow, x decreasing; sent only once the pipe is empty
    queue_item(OP_START, 5, 1, 1, 2, 32'h0F0F_0F0F, 1'b1);
    repeat (5) queue_step();
    // each coordinate off canvas in turn
    queue_item(OP_START, -1, 0, 0, 0, 32'h1111_1111);
    queue_item(OP_START, 0, -4096, 0, 0, 32'h2222_2222);
    queue_item(OP_START, 0, 0, -4096, 0, 32'h3333_3333);
    queue_item(OP_START, 0, 0, 0, -1, 32'h4444_4444);
    queue_step();  // after a reject: idle

    run_phase(4096, 4096, 380);
    run_phase(8191, 8191, 280);  // beyond 2^COORD_BITS: clamped
    run_phase(1, 4096, 150);
    run_phase(4096, 1, 150);
    run_phase(0, 0, 60);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 300);
    run_phase(640, 480, 300);

    wait_idle();
    if (n_fail == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
